// ===== src/idsv_pkg.sv =====
// Shared types and constants for the ISO date string validator.
// No dependencies; used by idsv_check and iso_date_string_validator.
package idsv_pkg;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned FIELD_W = 7;
	localparam int unsigned POS_W   = 4;

	localparam logic [7:0] CHAR_DASH = 8'h2D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// character positions within YYYY-MM-DD
	localparam logic [POS_W-1:0] POS_DASH1 = 4'd4;
	localparam logic [POS_W-1:0] POS_DASH2 = 4'd7;
	localparam logic [POS_W-1:0] POS_LAST  = 4'd9;
	localparam logic [POS_W-1:0] DATE_LEN  = 4'd10;
	localparam logic [POS_W-1:0] POS_MAX   = 4'd15;

	localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1900;

	localparam logic [FIELD_W-1:0] MON_FEB = 7'd2;
	localparam logic [FIELD_W-1:0] MON_APR = 7'd4;
	localparam logic [FIELD_W-1:0] MON_JUN = 7'd6;
	localparam logic [FIELD_W-1:0] MON_SEP = 7'd9;
	localparam logic [FIELD_W-1:0] MON_NOV = 7'd11;
	localparam logic [FIELD_W-1:0] MON_DEC = 7'd12;

	localparam logic [FIELD_W-1:0] DAYS_31 = 7'd31;
	localparam logic [FIELD_W-1:0] DAYS_30 = 7'd30;
	localparam logic [FIELD_W-1:0] DAYS_29 = 7'd29;
	localparam logic [FIELD_W-1:0] DAYS_28 = 7'd28;

	// accumulated date fields; year also kept as two decimal halves
	// (century digits and low digits) so the leap rule needs no divider
	typedef struct packed {
		logic               form_ok;
		logic [POS_W-1:0]   pos;
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] yr_hi;
		logic [FIELD_W-1:0] yr_lo;
		logic [FIELD_W-1:0] month;
		logic [FIELD_W-1:0] day;
	} date_fields_t;

	// cleared state: form intact, everything else zero
	localparam date_fields_t ACC_CLEAR = '{form_ok: 1'b1, default: '0};

endpackage

// ===== src/idsv_check.sv =====
// Final calendar check on the accumulated date fields.
// Depends on idsv_pkg.
module idsv_check (
	input  idsv_pkg::date_fields_t             fields,
	input  logic [idsv_pkg::YEAR_W-1:0]        min_year,
	output logic                               ok
);

	logic                          leap;
	logic [idsv_pkg::FIELD_W-1:0]  mon_len;

	// year = 100*hi + lo; 100 is a multiple of 4
	always_comb begin
		if (fields.yr_lo == '0) begin
			leap = (fields.yr_hi[1:0] == 2'b00);
		end else begin
			leap = (fields.yr_lo[1:0] == 2'b00);
		end
	end

	always_comb begin
		case (fields.month) inside
			idsv_pkg::MON_FEB: begin
				mon_len = leap ? idsv_pkg::DAYS_29 : idsv_pkg::DAYS_28;
			end
			idsv_pkg::MON_APR, idsv_pkg::MON_JUN, idsv_pkg::MON_SEP, idsv_pkg::MON_NOV: begin
				mon_len = idsv_pkg::DAYS_30;
			end
			default: begin
				mon_len = idsv_pkg::DAYS_31;
			end
		endcase
	end

	assign ok = fields.form_ok
		&& (fields.pos == idsv_pkg::POS_LAST)
		&& (fields.year >= min_year)
		&& (fields.month != '0) && (fields.month <= idsv_pkg::MON_DEC)
		&& (fields.day != '0) && (fields.day <= mon_len);

endmodule

// ===== src/iso_date_string_validator.sv =====
// Top level of the ISO date string validator (YYYY-MM-DD).
// Depends on idsv_pkg and idsv_check.

// One character is taken per item, is_last flagging the final one. Each
// accepted item lands in an input register; from there it updates the
// position, form flag and year/month/day accumulators, and a final item
// writes date_valid into the result register. Items are taken one per
// cycle; the single result register is the only thing that can stall the
// stream, and only while a result waits to be taken. date_valid is 1 when
// exactly ten characters arrived in the form YYYY-MM-DD, the year is at
// least min_year, the month is 1..12 and the day fits the month (Gregorian
// leap rule). After each result the accumulated state clears. min_year
// resets to 1900; the user writes it through cfg_we/cfg_wdata while idle,
// which the block itself does not enforce.
module iso_date_string_validator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [idsv_pkg::YEAR_W-1:0]  cfg_wdata,
	input  logic                         char_valid,
	output logic                         char_ready,
	input  logic [7:0]                   char_code,
	input  logic                         is_last,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic                         date_valid
);

	// input register
	logic       vld_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// accumulated state
	idsv_pkg::date_fields_t acc_q, acc_nxt, acc_step;
	logic [idsv_pkg::YEAR_W-1:0] min_year_q;

	// result register
	logic out_vld_q;
	logic date_valid_q;

	logic       out_free;
	logic       adv;
	logic       digit;
	logic [3:0] dval;
	logic       ok;

	// a non-final item never needs the result slot
	assign out_free   = !out_vld_q || result_ready;
	assign adv        = vld_s1 && (!last_s1 || out_free);
	assign char_ready = !vld_s1 || adv;

	assign digit = (char_s1 >= idsv_pkg::CHAR_ZERO) && (char_s1 <= idsv_pkg::CHAR_NINE);
	assign dval  = digit ? char_s1[3:0] : 4'd0;

	// fold the registered character into the accumulators
	always_comb begin
		acc_nxt = acc_q;
		if (acc_q.pos >= idsv_pkg::DATE_LEN) begin
			acc_nxt.form_ok = 1'b0;   // string too long
		end else if (acc_q.pos == idsv_pkg::POS_DASH1 || acc_q.pos == idsv_pkg::POS_DASH2) begin
			if (char_s1 != idsv_pkg::CHAR_DASH) begin
				acc_nxt.form_ok = 1'b0;
			end
		end else if (!digit) begin
			acc_nxt.form_ok = 1'b0;
		end else if (acc_q.pos < idsv_pkg::POS_DASH1) begin
			// x*10 + d = (x<<3) + (x<<1) + d, wrapping at field width
			acc_nxt.year = {acc_q.year[10:0], 3'b000} + {acc_q.year[12:0], 1'b0}
				+ {10'd0, dval};
			if (acc_q.pos[1] == 1'b0) begin
				acc_nxt.yr_hi = {acc_q.yr_hi[3:0], 3'b000} + {acc_q.yr_hi[5:0], 1'b0}
					+ {3'd0, dval};
			end else begin
				acc_nxt.yr_lo = {acc_q.yr_lo[3:0], 3'b000} + {acc_q.yr_lo[5:0], 1'b0}
					+ {3'd0, dval};
			end
		end else if (acc_q.pos < idsv_pkg::POS_DASH2) begin
			acc_nxt.month = {acc_q.month[3:0], 3'b000} + {acc_q.month[5:0], 1'b0}
				+ {3'd0, dval};
		end else begin
			acc_nxt.day = {acc_q.day[3:0], 3'b000} + {acc_q.day[5:0], 1'b0}
				+ {3'd0, dval};
		end
	end

	// non-final item: updated fields plus the saturating position step
	always_comb begin
		acc_step = acc_nxt;
		if (acc_q.pos != idsv_pkg::POS_MAX) begin
			acc_step.pos = acc_q.pos + 4'd1;
		end
	end

	idsv_check u_check (
		.fields   (acc_nxt),
		.min_year (min_year_q),
		.ok       (ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (char_ready) begin
			vld_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= idsv_pkg::MIN_YEAR_RST;
		end else if (cfg_we) begin
			min_year_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= idsv_pkg::ACC_CLEAR;
		end else if (adv) begin
			if (last_s1) begin
				acc_q <= idsv_pkg::ACC_CLEAR;
			end else begin
				acc_q <= acc_step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= adv && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv && last_s1) begin
			date_valid_q <= ok;
		end
	end

	assign result_valid = out_vld_q;
	assign date_valid   = date_valid_q;

	// state clears after each final item
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (acc_q.pos == '0) && acc_q.form_ok)
		else $error("state not cleared after final item");

	// a final item waits in the input register while the result slot is full
	a_hold_final: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && last_s1 && !out_free) |=> vld_s1 && last_s1)
		else $error("final item dropped while result pending");

	// a new result only follows a final item
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!result_valid ##1 result_valid) |-> $past(adv && last_s1))
		else $error("result without a final item");

	// position saturates
	a_pos_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q.pos == idsv_pkg::POS_MAX && adv && !last_s1) |=> acc_q.pos == idsv_pkg::POS_MAX)
		else $error("position wrapped");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for iso_date_string_validator.
// Depends on idsv_pkg and the block's RTL; needs no other file.
`timescale 1ns / 100ps

// Keeps a running copy of the parser state and queues the date_valid
// value that each final character should produce.
class date_scoreboard;
	logic [idsv_pkg::YEAR_W-1:0]  min_year;
	logic [idsv_pkg::POS_W-1:0]   pos;
	logic                         form_ok;
	logic [idsv_pkg::YEAR_W-1:0]  year;
	logic [idsv_pkg::FIELD_W-1:0] month;
	logic [idsv_pkg::FIELD_W-1:0] day;
	logic                         verdict_q[$];
	int                           errors;
	int                           checked;
	int                           valid_seen;

	function new();
		min_year   = idsv_pkg::MIN_YEAR_RST;
		errors     = 0;
		checked    = 0;
		valid_seen = 0;
		clear();
	endfunction

	function void clear();
		pos     = '0;
		form_ok = 1'b1;
		year    = '0;
		month   = '0;
		day     = '0;
	endfunction

	function int pending();
		return verdict_q.size();
	endfunction

	// one accepted character
	function void note_char(logic [7:0] c, logic last);
		logic       dig;
		logic [7:0] d;
		logic       ok;
		int         mlen;
		dig = (c >= idsv_pkg::CHAR_ZERO) && (c <= idsv_pkg::CHAR_NINE);
		d   = dig ? c - idsv_pkg::CHAR_ZERO : 8'd0;
		if (pos >= idsv_pkg::DATE_LEN) begin
			form_ok = 1'b0;
		end else if (pos == idsv_pkg::POS_DASH1 || pos == idsv_pkg::POS_DASH2) begin
			if (c != idsv_pkg::CHAR_DASH) form_ok = 1'b0;
		end else if (!dig) begin
			form_ok = 1'b0;
		end else if (pos < idsv_pkg::POS_DASH1) begin
			year = year * 10 + d;
		end else if (pos < idsv_pkg::POS_DASH2) begin
			month = month * 10 + d;
		end else begin
			day = day * 10 + d;
		end
		if (!last) begin
			if (pos != idsv_pkg::POS_MAX) pos++;
			return;
		end
		if (month == idsv_pkg::MON_FEB)
			mlen = (((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0) ? 29 : 28;
		else if (month == idsv_pkg::MON_APR || month == idsv_pkg::MON_JUN ||
				month == idsv_pkg::MON_SEP || month == idsv_pkg::MON_NOV)
			mlen = 30;
		else
			mlen = 31;
		ok = form_ok && (pos == idsv_pkg::POS_LAST) && (year >= min_year) &&
			(month >= 1) && (month <= idsv_pkg::MON_DEC) &&
			(day >= 1) && (day <= mlen);
		verdict_q.push_back(ok);
		clear();
	endfunction

	// one accepted result
	function void check_result(logic actual);
		logic want;
		checked++;
		if (actual === 1'b1) valid_seen++;
		if (verdict_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual date_valid=%b",
				$time, actual);
			return;
		end
		want = verdict_q.pop_front();
		if (actual !== want) begin
			errors++;
			$display("%0t: date_valid mismatch, expected %b, actual %b", $time, want, actual);
		end
	endfunction
endclass

module tb;

	localparam int ITEMS_PER_PHASE = 200;
	localparam int NUM_PHASES      = 8;
	localparam int DRAIN_CYCLES    = 6;   // idle margin after the last result
	localparam int HOLD_CYCLES     = 400; // long receiver stall, fills the block
	localparam int HOLD_AT         = 30;  // result count at which the stall starts

	logic                        clk;
	logic                        arst_n       = 1'b0;
	logic                        cfg_we       = 1'b0;
	logic [idsv_pkg::YEAR_W-1:0] cfg_wdata    = '0;
	logic                        char_valid   = 1'b0;
	logic                        char_ready;
	logic [7:0]                  char_code    = '0;
	logic                        is_last      = 1'b0;
	logic                        result_valid;
	logic                        result_ready = 1'b0;
	logic                        date_valid;

	date_scoreboard sb = new();

	// characters of the string being sent
	logic [7:0] line_q[$];
	int         chars_sent = 0;
	int         lines_sent = 0;
	bit         tx_calm    = 1'b0;
	bit         rx_calm    = 1'b0;

	iso_date_string_validator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.char_code   (char_code),
		.is_last     (is_last),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.date_valid  (date_valid)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#(5_000_000);
		$display("TEST FAILED");
		$finish;
	end

	// Offer one character and hold it until the block takes it. Outputs are
	// read right after the edge, so they still show the pre-edge values.
	// Stretches of back-to-back items alternate with random gaps.
	task automatic send_char(input logic [7:0] code, input logic last);
		int gap;
		if (chars_sent % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
		gap = tx_calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_code  <= code;
		is_last    <= last;
		@(posedge clk);
		while (!char_ready) @(posedge clk);
		sb.note_char(code, last);
		chars_sent++;
	endtask

	// Send line_q with the last flag on its final character, then empty it.
	task automatic send_line();
		for (int i = 0; i < line_q.size(); i++)
			send_char(line_q[i], i == line_q.size() - 1);
		line_q.delete();
		lines_sent++;
	endtask

	function automatic void put_digit(int v);
		line_q.push_back(8'(idsv_pkg::CHAR_ZERO + v));
	endfunction

	// Append YYYY-MM-DD; month and day may be any two-digit value.
	function automatic void put_date(int y, int m, int d);
		put_digit((y / 1000) % 10);
		put_digit((y / 100) % 10);
		put_digit((y / 10) % 10);
		put_digit(y % 10);
		line_q.push_back(idsv_pkg::CHAR_DASH);
		put_digit((m / 10) % 10);
		put_digit(m % 10);
		line_q.push_back(idsv_pkg::CHAR_DASH);
		put_digit((d / 10) % 10);
		put_digit(d % 10);
	endfunction

	// Mostly well-formed dates with the fields pushed toward their limits
	// (century and leap years, month ends, the configured minimum); the rest
	// are damaged dates and plain noise.
	task automatic make_random_line();
		int kind, y, m, d, n, sel;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			sel = $urandom_range(0, 3);
			case (sel)
				0: y = $urandom_range(0, 9999);
				1: y = $urandom_range(0, 99) * 100;
				2: y = $urandom_range(0, 2499) * 4;
				default: y = (int'(sb.min_year) + $urandom_range(0, 2) + 9999) % 10000;
			endcase
			m = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 99);
			sel = $urandom_range(0, 9);
			if (sel < 6)      d = $urandom_range(1, 31);
			else if (sel < 9) d = $urandom_range(27, 32);
			else              d = $urandom_range(0, 99);
			put_date(y, m, d);
			if (kind >= 70) begin
				// damage the date: bad character, short or long string
				sel = $urandom_range(0, 2);
				case (sel)
					0: line_q[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
					1: begin
						n = $urandom_range(1, 9);
						while (line_q.size() > n) void'(line_q.pop_back());
					end
					default: begin
						n = $urandom_range(1, 10);
						repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
					end
				endcase
			end
		end else begin
			n = $urandom_range(1, 16);
			repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic write_min_year(input logic [idsv_pkg::YEAR_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.min_year = v;
	endtask

	// Result side: random ready gaps, with one long hold-off so the result
	// register stays full and the character input backs up.
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sb.checked % 16 == 0) rx_calm = ($urandom_range(0, 3) == 0);
			gap = rx_calm ? 0 : $urandom_range(0, 14);
			if (!held && sb.checked == HOLD_AT) begin
				gap  = HOLD_CYCLES;
				held = 1'b1;
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			sb.check_result(date_valid);
		end
	end

	// Main sequence: reset, then one phase per min_year setting. The first
	// phase runs on the reset value; each later one is written while idle.
	initial begin
		logic [idsv_pkg::YEAR_W-1:0] phase_min[NUM_PHASES];
		int                          target;
		phase_min[0] = idsv_pkg::MIN_YEAR_RST;
		phase_min[1] = '0;
		phase_min[2] = '1;            // above 9999: nothing can pass
		phase_min[3] = 14'd9999;
		phase_min[4] = idsv_pkg::YEAR_W'($urandom_range(0, 9999));
		phase_min[5] = 14'd2000;
		phase_min[6] = 14'd1;
		phase_min[7] = idsv_pkg::YEAR_W'($urandom_range(0, 9999));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				while (sb.pending() != 0) @(posedge clk);
				repeat (DRAIN_CYCLES) @(posedge clk);
				write_min_year(phase_min[ph]);
			end
			if (ph == 0) begin
				// leap day in a 400-year century, then in a plain century
				put_date(2000, 2, 29);
				send_line();
				put_date(2100, 2, 29);
				send_line();
				// lone final characters: code zero and all ones, too short
				line_q.push_back(8'h00);
				send_line();
				line_q.push_back(8'hFF);
				send_line();
			end
			target = chars_sent + ITEMS_PER_PHASE;
			while (chars_sent < target) begin
				make_random_line();
				send_line();
			end
			char_valid <= 1'b0;
		end

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES * 2) @(posedge clk);

		$display("Covered %0d characters in %0d strings under %0d min_year settings.",
			chars_sent, lines_sent, NUM_PHASES);
		$display("Checked %0d results, %0d of them valid dates; %0d mismatches.",
			sb.checked, sb.valid_seen, sb.errors);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
